// File: hdl/bms_pkg.sv
// ----------------------------------------------------------------------------
// Buzzer melody sequencer package
// Shared opcode and state types and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

   localparam int unsigned HZ_WIDTH      = 16;
   localparam int unsigned DUR_WIDTH     = 16;
   localparam int unsigned POS_WIDTH     = 9;
   localparam int unsigned COUNT_WIDTH   = 9;
   localparam int unsigned RELOAD_WIDTH  = 20;
   localparam int unsigned COMPARE_WIDTH = 19;
   localparam int unsigned ENTRY_WIDTH   = HZ_WIDTH + DUR_WIDTH;
   localparam int unsigned STEP_WIDTH    = 5;

   localparam logic [RELOAD_WIDTH-1:0] PERIOD_NUMERATOR = 20'd1000000;
   localparam logic [STEP_WIDTH-1:0]   LAST_STEP        = STEP_WIDTH'(RELOAD_WIDTH - 1);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_STOP  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage : bms_pkg

`default_nettype wire

// File: hdl/bms_req_if.sv
// ----------------------------------------------------------------------------
// Buzzer melody sequencer request channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bms_req_if;
   import bms_pkg::*;

   logic                 valid;
   logic                 ready;
   opcode_type           opcode;
   logic [7:0]           entry_index;
   logic [HZ_WIDTH-1:0]  note_hz;
   logic [DUR_WIDTH-1:0] duration_ms;

   modport source (output valid, output opcode, output entry_index,
                   output note_hz, output duration_ms, input ready);
   modport sink   (input valid, input opcode, input entry_index,
                   input note_hz, input duration_ms, output ready);
endinterface : bms_req_if

`default_nettype wire

// File: hdl/bms_rsp_if.sv
// ----------------------------------------------------------------------------
// Buzzer melody sequencer response channel
// Valid/ready channel carrying one status item per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface bms_rsp_if;
   import bms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     pwm_enable;
   logic [RELOAD_WIDTH-1:0]  reload_value;
   logic [COMPARE_WIDTH-1:0] compare_value;
   logic                     note_loaded;
   logic                     finished;

   modport source (output valid, output pwm_enable, output reload_value,
                   output compare_value, output note_loaded, output finished,
                   input ready);
   modport sink   (input valid, input pwm_enable, input reload_value,
                   input compare_value, input note_loaded, input finished,
                   output ready);
endinterface : bms_rsp_if

`default_nettype wire

// File: hdl/buzzer_melody_sequencer_core.sv
// ----------------------------------------------------------------------------
// Buzzer melody sequencer core
// Script memory, playback sequencer and period divider for a PWM buzzer.
// ----------------------------------------------------------------------------
// Write, start, stop and ticks that load nothing go from the accept state
// straight to the done state, which hands the item to the output register.
// A tick that loads a rest adds a pass through the script memory read; a
// tick that loads a tone adds that read plus the bit-serial restoring
// divider that forms 1000000/frequency. The compare value is that
// quotient halved. A new item is accepted while a finished item still
// waits in the output register. No clearing pass.
`default_nettype none

module buzzer_melody_sequencer_core #(
   parameter int unsigned SCRIPT_DEPTH = 256
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire [bms_pkg::COUNT_WIDTH-1:0] csr_wdata,
   bms_req_if.sink                    req_if,
   bms_rsp_if.source                  rsp_if
);
   import bms_pkg::*;

   localparam int unsigned AW = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;

   logic [ENTRY_WIDTH-1:0] script_mem [SCRIPT_DEPTH];
   logic [ENTRY_WIDTH-1:0] rdata_ff;

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0]   note_count_ff;
   logic [POS_WIDTH-1:0]     position_ff;
   logic [DUR_WIDTH-1:0]     countdown_ff;
   logic                     playing_ff;
   logic [RELOAD_WIDTH-1:0]  period_ff;
   logic [COMPARE_WIDTH-1:0] compare_ff;
   logic                     loaded_ff;
   logic                     finished_ff;

   logic [HZ_WIDTH-1:0]      divisor_ff;
   logic [HZ_WIDTH:0]        rem_ff;
   logic [RELOAD_WIDTH-1:0]  quo_ff;
   logic [STEP_WIDTH-1:0]    step_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_enable_ff;
   logic [RELOAD_WIDTH-1:0]  rsp_reload_ff;
   logic [COMPARE_WIDTH-1:0] rsp_compare_ff;
   logic                     rsp_loaded_ff;
   logic                     rsp_finished_ff;

   logic                     accept;
   logic                     out_free;
   logic                     rsp_load;
   logic                     need_load;
   logic                     mem_we;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr;
   logic                     pos_in_range;
   logic [ENTRY_WIDTH-1:0]   entry;
   logic [HZ_WIDTH-1:0]      entry_hz;
   logic [POS_WIDTH:0]       next_pos;
   logic                     melody_end;
   logic [HZ_WIDTH:0]        shifted;
   logic                     quo_bit;
   logic [RELOAD_WIDTH-1:0]  quo_next;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = need_load ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            state_in = (entry_hz == '0) ? ST_DONE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_if.ready;
      req_if.ready = (state_ff == ST_IDLE);
      accept       = req_if.valid && (state_ff == ST_IDLE);
      need_load    = (req_if.opcode == OP_TICK) && playing_ff && (countdown_ff == '0);
      mem_we       = accept && (req_if.opcode == OP_WRITE)
                     && (32'(req_if.entry_index) < 32'(SCRIPT_DEPTH));
      rsp_load     = (state_ff == ST_DONE) && out_free;
   end

   always_comb begin
      wr_addr      = AW'(req_if.entry_index);
      rd_addr      = AW'(position_ff);
      pos_in_range = 32'(position_ff) < 32'(SCRIPT_DEPTH);
      entry        = pos_in_range ? rdata_ff : '0;
      entry_hz     = entry[HZ_WIDTH-1:0];
      next_pos     = {1'b0, position_ff} + 1'b1;
      melody_end   = next_pos >= {1'b0, note_count_ff};
      shifted      = {rem_ff[HZ_WIDTH-1:0], quo_ff[RELOAD_WIDTH-1]};
      quo_bit      = shifted >= {1'b0, divisor_ff};
      quo_next     = {quo_ff[RELOAD_WIDTH-2:0], quo_bit};
   end

   // script memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         script_mem[wr_addr] <= {req_if.duration_ms, req_if.note_hz};
      end
      rdata_ff <= script_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         note_count_ff <= '0;
         position_ff   <= '0;
         countdown_ff  <= '0;
         playing_ff    <= 1'b0;
         period_ff     <= '0;
         compare_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            note_count_ff <= csr_wdata;
         end
         if (accept) begin
            unique case (req_if.opcode)
               OP_START: playing_ff <= 1'b1;
               OP_STOP: begin
                  playing_ff  <= 1'b0;
                  position_ff <= '0;
               end
               OP_TICK: begin
                  if (playing_ff && (countdown_ff != '0)) begin
                     countdown_ff <= countdown_ff - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_READ) begin
            if (melody_end) begin
               position_ff  <= '0;
               playing_ff   <= 1'b0;
               countdown_ff <= '0;
            end else begin
               position_ff  <= next_pos[POS_WIDTH-1:0];
               countdown_ff <= entry[ENTRY_WIDTH-1:HZ_WIDTH];
            end
            if (entry_hz == '0) begin
               period_ff <= '0;
            end
         end
         if ((state_ff == ST_DIVIDE) && (step_ff == LAST_STEP)) begin
            period_ff  <= quo_next;
            compare_ff <= quo_next[RELOAD_WIDTH-1:1];
         end
      end
   end

   // per-item flags and divider datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         loaded_ff   <= need_load;
         finished_ff <= 1'b0;
      end
      if (state_ff == ST_READ) begin
         finished_ff <= melody_end;
         divisor_ff  <= entry_hz;
         rem_ff      <= '0;
         quo_ff      <= PERIOD_NUMERATOR;
         step_ff     <= '0;
      end
      if (state_ff == ST_DIVIDE) begin
         rem_ff  <= quo_bit ? (shifted - {1'b0, divisor_ff}) : shifted;
         quo_ff  <= quo_next;
         step_ff <= step_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_enable_ff   <= playing_ff;
         rsp_reload_ff   <= period_ff;
         rsp_compare_ff  <= compare_ff;
         rsp_loaded_ff   <= loaded_ff;
         rsp_finished_ff <= finished_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.pwm_enable    = rsp_enable_ff;
   assign rsp_if.reload_value  = rsp_reload_ff;
   assign rsp_if.compare_value = rsp_compare_ff;
   assign rsp_if.note_loaded   = rsp_loaded_ff;
   assign rsp_if.finished      = rsp_finished_ff;

   a_finish_needs_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_finished_ff |-> rsp_loaded_ff && !rsp_enable_ff)
      else $error("finished item without a load or with pwm still enabled");

   a_compare_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_loaded_ff && (rsp_reload_ff != '0)
      |-> rsp_compare_ff == rsp_reload_ff[RELOAD_WIDTH-1:1])
      else $error("compare is not half of the loaded period");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_DIVIDE || state_ff == ST_DONE)
      else $error("memory read state did not advance");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !out_free |=> state_ff == ST_DONE)
      else $error("item left done state while output register full");

endmodule : buzzer_melody_sequencer_core

`default_nettype wire
